@@ hdl/dsmrc_pkg.sv @@
// Shared types and constants for the RC serial frame decoder.
// No dependencies; imported by every module of the block.
package dsmrc_pkg;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_HI_RES     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MID_VALUE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHAN_MAP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 3'd4;

	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_READ = 1'b1;

	localparam logic [11:0] BASE_VALUE     = 12'd988;
	localparam logic        RST_HI_RES     = 1'b1;
	localparam logic [3:0]  RST_CHANS      = 4'd8;
	localparam logic [11:0] RST_MID_VALUE  = 12'd1500;
	localparam logic [23:0] RST_CHAN_MAP   = 24'hFAC688;
	localparam logic [15:0] RST_GAP_LIMIT  = 16'd5000;

	typedef struct packed {
		logic        hi_res;
		logic [3:0]  chans_in_use;
		logic [11:0] mid_value;
		logic [23:0] chan_map;
		logic [15:0] gap_limit;
	} dsmrc_cfg_t;

	// current frame status
	typedef struct packed {
		logic full;
		logic seen;
	} dsmrc_stat_t;

	// per-item flags as they stand after the step
	typedef struct packed {
		logic done;
		logic ready;
		logic seen;
	} dsmrc_step_t;

endpackage

@@ hdl/dsmrc_frame_buf.sv @@
// Byte capture: frame slot position, gap timing, frame byte registers.
// Depends on dsmrc_pkg.
module dsmrc_frame_buf #(
	parameter int FRAME_BYTES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dsmrc_pkg::dsmrc_cfg_t   cfg,
	input  logic                    accept,
	input  logic                    is_read,
	input  logic [7:0]              rx_byte,
	input  logic [31:0]             time_us,
	output logic [7:0]              frame_bytes [FRAME_BYTES],
	output dsmrc_pkg::dsmrc_stat_t  stat,
	output dsmrc_pkg::dsmrc_step_t  step
);
	import dsmrc_pkg::*;

	localparam int PW = $clog2(FRAME_BYTES);
	localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1);

	logic [PW-1:0] pos_q;
	logic [31:0]   last_q;
	logic          full_q;
	logic          seen_q;
	logic [31:0]   interval;
	logic          gap;
	logic [PW-1:0] slot;
	logic          at_last;
	logic          byte_we;
	logic          rd_en;

	assign byte_we  = accept && (is_read == MODE_BYTE);
	assign rd_en    = accept && (is_read == MODE_READ);
	assign interval = time_us - last_q;
	assign gap      = interval > {16'b0, cfg.gap_limit};
	assign slot     = gap ? '0 : pos_q;
	assign at_last  = (slot == LAST_POS);

	always_comb begin
		if (is_read == MODE_READ) begin
			step.done  = 1'b0;
			step.ready = 1'b0;
			step.seen  = seen_q;
		end else begin
			step.done  = at_last;
			step.ready = full_q | at_last;
			step.seen  = 1'b1;
		end
	end

	assign stat.full = full_q;
	assign stat.seen = seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			last_q <= '0;
			full_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (byte_we) begin
			last_q <= time_us;
			seen_q <= 1'b1;
			if (at_last) begin
				pos_q  <= slot;
				full_q <= 1'b1;
			end else begin
				pos_q <= slot + 1'b1;
			end
		end else if (rd_en) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < FRAME_BYTES; i++) begin
			if (byte_we && (slot == PW'(i))) begin
				frame_bytes[i] <= rx_byte;
			end
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("frame position beyond last slot");
	a_done_full: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_we && at_last) |=> (full_q && pos_q == LAST_POS))
		else $error("frame completion not recorded");
	a_read_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> !full_q)
		else $error("frame still pending after read");

endmodule

@@ hdl/dsmrc_chan_store.sv @@
// Frame decode into the channel store and mapped channel lookup.
// Depends on dsmrc_pkg; takes frame bytes from dsmrc_frame_buf.
module dsmrc_chan_store #(
	parameter int FRAME_BYTES  = 16,
	parameter int MAX_CHANNELS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dsmrc_pkg::dsmrc_cfg_t  cfg,
	input  dsmrc_pkg::dsmrc_stat_t stat,
	input  logic                   rd_en,
	input  logic [3:0]             channel,
	input  logic [7:0]             frame_bytes [FRAME_BYTES],
	output logic [11:0]            channel_value
);
	import dsmrc_pkg::*;

	localparam int NWORDS = (FRAME_BYTES - 1) / 2;

	logic [10:0] store_q  [MAX_CHANNELS];
	logic [10:0] store_nx [MAX_CHANNELS];
	logic [3:0]  word_id  [NWORDS];
	logic [10:0] word_val [NWORDS];
	logic [2:0]  slot;
	logic        slot_ok;
	logic [10:0] v_sel;
	logic [10:0] v_scaled;

	always_comb begin
		for (int w = 0; w < NWORDS; w++) begin
			if (cfg.hi_res) begin
				word_id[w]  = frame_bytes[2*w+2][6:3];
				word_val[w] = {frame_bytes[2*w+2][2:0], frame_bytes[2*w+3]};
			end else begin
				word_id[w]  = frame_bytes[2*w+2][5:2];
				word_val[w] = {1'b0, frame_bytes[2*w+2][1:0], frame_bytes[2*w+3]};
			end
		end
	end

	// later words win, ids with no entry fall out
	always_comb begin
		for (int e = 0; e < MAX_CHANNELS; e++) begin
			store_nx[e] = store_q[e];
			for (int w = 0; w < NWORDS; w++) begin
				if (stat.full && ({1'b0, word_id[w]} == 5'(e))) begin
					store_nx[e] = word_val[w];
				end
			end
		end
	end

	assign slot    = cfg.chan_map[3*channel[2:0] +: 3];
	assign slot_ok = ({2'b0, slot} < 5'(MAX_CHANNELS));

	always_comb begin
		v_sel = '0;
		for (int e = 0; e < MAX_CHANNELS; e++) begin
			if ({2'b0, slot} == 5'(e)) begin
				v_sel = store_nx[e];
			end
		end
	end

	assign v_scaled = cfg.hi_res ? {1'b0, v_sel[10:1]} : v_sel;

	always_comb begin
		if (stat.seen && (channel < cfg.chans_in_use) && !channel[3] && slot_ok) begin
			channel_value = BASE_VALUE + {1'b0, v_scaled};
		end else begin
			channel_value = cfg.mid_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int e = 0; e < MAX_CHANNELS; e++) begin
				store_q[e] <= '0;
			end
		end else if (rd_en) begin
			for (int e = 0; e < MAX_CHANNELS; e++) begin
				store_q[e] <= store_nx[e];
			end
		end
	end

endmodule

@@ hdl/dsm_rc_frame_decoder_unit.sv @@
// RC serial frame decoder top level: config registers, input and output channels.
// Depends on dsmrc_pkg, dsmrc_frame_buf and dsmrc_chan_store.
//
// Input channel (s_*): each item is either a received byte (tuser = 0) with its
// microsecond timestamp, or a channel read request (tuser = 1). Every item
// gives exactly one result item on the output channel (m_*).
// A byte restarts the frame when the gap since the previous byte exceeds
// gap_limit_us; the byte that fills the last slot sets tlast (failsafe clear).
// A read decodes any complete frame into the channel store and returns the
// mapped channel value, or mid_value when no data or out of range.
// The result is registered and valid in the cycle after input accept. Throughput: one
// item per cycle while results are taken; the whole step is one pass of logic
// between the input handshake and the output register.
// Stall: the output register holds its result while m_tready is low; a new
// item is taken in the cycle the held result is taken.
// Reset: frame position, timing, flags and channel store clear; registers take
// their defaults; frame bytes stay undefined until written.
// Config writes (cfg_*) are always ready and must be made while idle.
module dsm_rc_frame_decoder_unit #(
	parameter int FRAME_BYTES  = 16,
	parameter int MAX_CHANNELS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [dsmrc_pkg::IN_TDATA_W-1:0]    s_tdata,   // rx_byte[7:0], time_us[39:8], channel[43:40]
	input  logic                                s_tuser,   // mode
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [dsmrc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // channel_value[11:0], frame_ready[12], has_data[13]
	output logic                                m_tlast,   // frame_done
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dsmrc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsmrc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dsmrc_pkg::*;

	dsmrc_cfg_t  cfg_q;
	dsmrc_stat_t stat;
	dsmrc_step_t step;
	logic        accept;
	logic        rd_en;
	logic [11:0] chan_value;
	logic [7:0]  frame_bytes [FRAME_BYTES];
	logic        out_valid_q;
	logic [11:0] value_q;
	logic        done_q;
	logic        ready_q;
	logic        seen_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign rd_en     = accept && (s_tuser == MODE_READ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hi_res       <= RST_HI_RES;
			cfg_q.chans_in_use <= RST_CHANS;
			cfg_q.mid_value    <= RST_MID_VALUE;
			cfg_q.chan_map     <= RST_CHAN_MAP;
			cfg_q.gap_limit    <= RST_GAP_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HI_RES:    cfg_q.hi_res       <= cfg_data[0];
				CFG_CHANS:     cfg_q.chans_in_use <= cfg_data[3:0];
				CFG_MID_VALUE: cfg_q.mid_value    <= cfg_data[11:0];
				CFG_CHAN_MAP:  cfg_q.chan_map     <= cfg_data[23:0];
				CFG_GAP_LIMIT: cfg_q.gap_limit    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	dsmrc_frame_buf #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_frame_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.is_read     (s_tuser),
		.rx_byte     (s_tdata[7:0]),
		.time_us     (s_tdata[39:8]),
		.frame_bytes (frame_bytes),
		.stat        (stat),
		.step        (step)
	);

	dsmrc_chan_store #(
		.FRAME_BYTES  (FRAME_BYTES),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_chan_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.stat          (stat),
		.rd_en         (rd_en),
		.channel       (s_tdata[43:40]),
		.frame_bytes   (frame_bytes),
		.channel_value (chan_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= (s_tuser == MODE_READ) ? chan_value : 12'd0;
			done_q  <= step.done;
			ready_q <= step.ready;
			seen_q  <= step.seen;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b0, seen_q, ready_q, value_q};
	assign m_tlast  = done_q;

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input blocked with empty output register");
	a_accept_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result");
	a_read_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> (!done_q && !ready_q))
		else $error("read result carries frame flags");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for dsm_rc_frame_decoder_unit: stream driver, result monitor
// and an in-bench frame decoder model that predicts every result item.
// Depends on dsmrc_pkg and the dsm_rc_frame_decoder_unit RTL.
module tb;
	import dsmrc_pkg::*;

	localparam int FRAME_LEN = 16;
	localparam int NUM_SLOTS = 8;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic        mode;
		logic [7:0]  rx_byte;
		logic [31:0] stamp;
		logic [3:0]  chan;
	} item_t;

	typedef struct packed {
		logic [11:0] value;
		logic        done;
		logic        ready;
		logic        seen;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	dsm_rc_frame_decoder_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// decoder model state
	dsmrc_cfg_t  cfg_shadow;
	logic [7:0]  frame_buf [FRAME_LEN];
	logic [3:0]  wr_pos;
	logic [31:0] last_stamp;
	logic        frame_pending;
	logic        bytes_seen;
	logic [10:0] chan_store [NUM_SLOTS];

	item_t rx_items [$];
	res_t  expected_results [$];
	item_t drv_item;
	res_t  want;
	bit    item_taken;
	int    src_idle;
	int    snk_stall;
	int    idle_cycles;
	int    err_cnt;
	int    queued;
	logic [31:0] gen_stamp;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic res_t frame_decoder_step(item_t it);
		res_t r;
		logic [31:0] gap;
		logic [7:0] hi;
		logic [3:0] id;
		logic [10:0] v;
		logic [2:0] slot;
		r = '0;
		if (it.mode == MODE_BYTE) begin
			gap = it.stamp - last_stamp;
			bytes_seen = 1'b1;
			last_stamp = it.stamp;
			if (gap > {16'd0, cfg_shadow.gap_limit})
				wr_pos = '0;
			frame_buf[wr_pos] = it.rx_byte;
			if (wr_pos == 4'(FRAME_LEN - 1)) begin
				frame_pending = 1'b1;
				r.done = 1'b1;
			end else begin
				wr_pos++;
			end
		end else begin
			if (frame_pending) begin
				// seven words: id and value high bits in the first byte, value low in the second
				for (int b = 3; b < FRAME_LEN; b += 2) begin
					hi = frame_buf[b-1];
					id = cfg_shadow.hi_res ? hi[6:3] : hi[5:2];
					if (id < NUM_SLOTS)
						chan_store[id[2:0]] = cfg_shadow.hi_res ? {hi[2:0], frame_buf[b]}
							: {1'b0, hi[1:0], frame_buf[b]};
				end
				frame_pending = 1'b0;
			end
			r.value = cfg_shadow.mid_value;
			if (bytes_seen && it.chan < cfg_shadow.chans_in_use && it.chan < NUM_SLOTS) begin
				slot = cfg_shadow.chan_map[3*it.chan +: 3];
				v = chan_store[slot];
				r.value = BASE_VALUE + (cfg_shadow.hi_res ? {2'b0, v[10:1]} : {1'b0, v});
			end
		end
		r.ready = frame_pending;
		r.seen = bytes_seen;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("ERROR t=%0t %s: got 0x%0h, want 0x%0h", $time, what, got, exp_val);
		err_cnt++;
	endtask

	// driver: new item at the falling edge once the held one is taken
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || item_taken)) begin
			if (rx_items.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
				drv_item = rx_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= drv_item.mode;
				s_tdata <= {4'h0, drv_item.chan, drv_item.stamp, drv_item.rx_byte};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n)
			m_tready <= ($urandom_range(0, 99) >= snk_stall);
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with none expected", 32'(m_tdata), 32'd0);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[11:0] !== want.value)
						report_mismatch("channel_value", 32'(m_tdata[11:0]),
							32'(want.value));
					if (m_tlast !== want.done)
						report_mismatch("frame_done", 32'(m_tlast), 32'(want.done));
					if (m_tdata[12] !== want.ready)
						report_mismatch("frame_ready", 32'(m_tdata[12]), 32'(want.ready));
					if (m_tdata[13] !== want.seen)
						report_mismatch("has_data", 32'(m_tdata[13]), 32'(want.seen));
				end
			end
			item_taken = s_tvalid && s_tready;
			if (item_taken)
				expected_results.push_back(frame_decoder_step({s_tuser, s_tdata[7:0],
					s_tdata[39:8], s_tdata[43:40]}));
			if (item_taken || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("dsm_rc_frame_decoder_unit: mismatch");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_HI_RES:    cfg_shadow.hi_res = val[0];
			CFG_CHANS:     cfg_shadow.chans_in_use = val[3:0];
			CFG_MID_VALUE: cfg_shadow.mid_value = val[11:0];
			CFG_CHAN_MAP:  cfg_shadow.chan_map = val[23:0];
			CFG_GAP_LIMIT: cfg_shadow.gap_limit = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] b, input logic [31:0] st);
		rx_items.push_back({MODE_BYTE, b, st, 4'h0});
		gen_stamp = st;
		queued++;
	endtask

	task automatic add_read(input logic [3:0] ch);
		rx_items.push_back({MODE_READ, 8'h00, 32'h0, ch});
		queued++;
	endtask

	// first byte lands past the gap limit, the rest within it (sometimes exactly at it)
	task automatic send_frame(input int nbytes);
		logic [31:0] st;
		st = gen_stamp + cfg_shadow.gap_limit + 32'd1 + ($urandom_range(0, 1) ?
			$urandom_range(0, 50) : $urandom_range(0, 32'h7FFF_0000));
		for (int i = 0; i < nbytes; i++) begin
			if (i > 0)
				st = gen_stamp + (($urandom_range(0, 7) == 0) ? cfg_shadow.gap_limit
					: $urandom_range(0, cfg_shadow.gap_limit));
			add_byte(8'($urandom_range(0, 255)), st);
		end
	endtask

	task automatic fill_random(input int n);
		int target;
		int r;
		target = queued + n;
		while (queued < target) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				send_frame(FRAME_LEN + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0));
				repeat ($urandom_range(1, 4))
					add_read(4'($urandom_range(0, 1) ? $urandom_range(0, 7)
						: $urandom_range(0, 15)));
			end else if (r < 75) begin
				add_read(4'($urandom_range(0, 1) ? $urandom_range(0, 7)
					: $urandom_range(0, 15)));
			end else if (r < 88) begin
				send_frame($urandom_range(1, FRAME_LEN - 1));
			end else begin
				add_byte(8'($urandom_range(0, 255)), gen_stamp
					+ $urandom_range(0, 2 * cfg_shadow.gap_limit + 2));
			end
		end
	endtask

	task automatic wait_drained;
		while (rx_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	logic [7:0] dir_bytes [FRAME_LEN] = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h0F, 8'hFF,
		8'hFF, 8'hFF, 8'h3A, 8'h5C, 8'h80, 8'h01, 8'h47, 8'h80, 8'h12, 8'h34};
	logic [3:0] dir_reads [6] = '{4'd0, 4'd1, 4'd2, 4'd7, 4'd8, 4'd15};

	initial begin
		logic        hi;
		logic [3:0]  chans;
		logic [11:0] mid;
		logic [23:0] cmap;
		logic [15:0] gap;
		cfg_shadow = '{hi_res: RST_HI_RES, chans_in_use: RST_CHANS, mid_value: RST_MID_VALUE,
			chan_map: RST_CHAN_MAP, gap_limit: RST_GAP_LIMIT};
		foreach (frame_buf[i]) frame_buf[i] = '0;
		foreach (chan_store[i]) chan_store[i] = '0;
		wr_pos = '0;
		last_stamp = '0;
		frame_pending = 1'b0;
		bytes_seen = 1'b0;
		item_taken = 1'b0;
		src_idle = 0;
		snk_stall = 0;
		idle_cycles = 0;
		err_cnt = 0;
		queued = 0;
		gen_stamp = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < 8; p++) begin
			if (p > 0) begin
				hi = 1'($urandom_range(0, 1));
				chans = 4'd8;
				mid = 12'($urandom_range(0, 4095));
				cmap = 24'($urandom());
				gap = 16'd5000;
				case (p)
					1: begin hi = 1'b0; mid = 12'd4095; cmap = RST_CHAN_MAP; end
					2: begin hi = 1'b1; chans = 4'd0; mid = 12'd0; cmap = 24'h0; gap = 16'd0; end
					3: begin hi = 1'b0; chans = 4'd5; cmap = 24'hFFFFFF; gap = 16'hFFFF; end
					4: begin hi = 1'b1; mid = RST_MID_VALUE; gap = 16'($urandom_range(1, 300)); end
					5: begin hi = 1'b0; chans = 4'($urandom_range(0, 8)); gap = 16'($urandom()); end
					6: hi = 1'b1;
					default: begin cmap = RST_CHAN_MAP; gap = 16'd20; end
				endcase
				write_reg(CFG_HI_RES, CFG_DATA_W'(hi));
				write_reg(CFG_CHANS, CFG_DATA_W'(chans));
				write_reg(CFG_MID_VALUE, CFG_DATA_W'(mid));
				write_reg(CFG_CHAN_MAP, cmap);
				write_reg(CFG_GAP_LIMIT, CFG_DATA_W'(gap));
			end
			case (p % 4)
				0: begin src_idle = 0; snk_stall = 0; end
				1: begin src_idle = 70; snk_stall = 0; end
				2: begin src_idle = 0; snk_stall = 70; end
				default: begin src_idle = 30; snk_stall = 30; end
			endcase
			if (p == 0) begin
				// read before any byte, then a frame whose timestamps end at the top of the 32-bit range
				add_read(4'd3);
				for (int i = 0; i < FRAME_LEN; i++)
					add_byte(dir_bytes[i], 32'hFFFF_FFF0 + 32'(i));
				// gap exactly at the limit overwrites the last slot, one more restarts
				add_byte(8'hAA, gen_stamp + RST_GAP_LIMIT);
				add_byte(8'h55, gen_stamp + RST_GAP_LIMIT + 32'd1);
				foreach (dir_reads[i]) add_read(dir_reads[i]);
			end
			fill_random(145);
			wait_drained();
		end

		if (err_cnt == 0 && expected_results.size() == 0)
			$display("dsm_rc_frame_decoder_unit: match");
		else
			$display("dsm_rc_frame_decoder_unit: mismatch");
		$finish;
	end

endmodule
